// File: rtl/eau_pkg.sv
`default_nettype none
package eau_pkg;

  localparam int unsigned AddrWidth = 16;
  localparam int unsigned ByteWidth = 8;

  // transaction kinds on the request channel
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // addressing modes
  localparam logic [3:0] MODE_IMM  = 4'd0;
  localparam logic [3:0] MODE_ABS  = 4'd1;
  localparam logic [3:0] MODE_ZP   = 4'd2;
  localparam logic [3:0] MODE_IMPL = 4'd3;
  localparam logic [3:0] MODE_IND  = 4'd4;
  localparam logic [3:0] MODE_ABSX = 4'd5;
  localparam logic [3:0] MODE_ABSY = 4'd6;
  localparam logic [3:0] MODE_ZPX  = 4'd7;
  localparam logic [3:0] MODE_ZPY  = 4'd8;
  localparam logic [3:0] MODE_IZX  = 4'd9;
  localparam logic [3:0] MODE_IZY  = 4'd10;
  localparam logic [3:0] MODE_IPX  = 4'd11;
  localparam logic [3:0] MODE_IPY  = 4'd12;
  localparam logic [3:0] MODE_ACC  = 4'd13;

  // fetch phases
  localparam logic [1:0] PH_OPLO  = 2'd0;
  localparam logic [1:0] PH_OPHI  = 2'd1;
  localparam logic [1:0] PH_PTRLO = 2'd2;
  localparam logic [1:0] PH_PTRHI = 2'd3;

  typedef struct packed {
    logic                  busy;
    logic [3:0]            active_mode;
    logic [1:0]            phase;
    logic [AddrWidth-1:0]  pc_copy;
    logic [ByteWidth-1:0]  x_copy;
    logic [ByteWidth-1:0]  y_copy;
    logic [AddrWidth-1:0]  pointer;
    logic [ByteWidth-1:0]  address_build;
  } calc_state_t;

  typedef struct packed {
    logic                  done_res;
    logic [AddrWidth-1:0]  read_address;
    logic [AddrWidth-1:0]  effective_address;
    logic [AddrWidth-1:0]  next_pc;
    logic                  protocol_error;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/eau_step.sv
`default_nettype none
module eau_step (
  input  wire logic                       op,
  input  wire logic [3:0]                 mode,
  input  wire logic [eau_pkg::AddrWidth-1:0] prog_counter,
  input  wire logic [eau_pkg::ByteWidth-1:0] index_x,
  input  wire logic [eau_pkg::ByteWidth-1:0] index_y,
  input  wire logic [eau_pkg::ByteWidth-1:0] accum,
  input  wire logic [eau_pkg::ByteWidth-1:0] read_data,
  input  wire eau_pkg::calc_state_t       st,
  output eau_pkg::calc_state_t            st_next,
  output eau_pkg::result_t                res
);

  logic [eau_pkg::AddrWidth-1:0] full;
  logic [eau_pkg::ByteWidth-1:0] zp_x;
  logic [eau_pkg::ByteWidth-1:0] zp_y;
  logic [eau_pkg::ByteWidth-1:0] ptr_lo_inc;
  logic [eau_pkg::AddrWidth-1:0] pc_inc1;
  logic [eau_pkg::AddrWidth-1:0] pc_inc2;

  assign full       = {read_data, st.address_build};
  assign zp_x       = read_data + st.x_copy;
  assign zp_y       = read_data + st.y_copy;
  assign ptr_lo_inc = st.pointer[eau_pkg::ByteWidth-1:0] + 8'd1;
  assign pc_inc1    = st.pc_copy + 16'd1;
  assign pc_inc2    = st.pc_copy + 16'd2;

  always_comb begin
    st_next = st;
    res     = '0;
    if (op == eau_pkg::OP_START) begin
      if (st.busy) begin
        res.protocol_error = 1'b1;
      end else begin
        case (mode)
          eau_pkg::MODE_IMM: begin
            res.done_res          = 1'b1;
            res.effective_address = prog_counter;
            res.next_pc           = prog_counter + 16'd1;
          end
          eau_pkg::MODE_ACC: begin
            res.done_res          = 1'b1;
            res.effective_address = {8'h00, accum};
            res.next_pc           = prog_counter;
          end
          eau_pkg::MODE_ABS, eau_pkg::MODE_ZP, eau_pkg::MODE_IND, eau_pkg::MODE_ABSX,
          eau_pkg::MODE_ABSY, eau_pkg::MODE_ZPX, eau_pkg::MODE_ZPY, eau_pkg::MODE_IZX,
          eau_pkg::MODE_IZY, eau_pkg::MODE_IPX, eau_pkg::MODE_IPY: begin
            st_next.busy          = 1'b1;
            st_next.active_mode   = mode;
            st_next.phase         = eau_pkg::PH_OPLO;
            st_next.pc_copy       = prog_counter;
            st_next.x_copy        = index_x;
            st_next.y_copy        = index_y;
            st_next.pointer       = '0;
            st_next.address_build = '0;
            res.read_address      = prog_counter;
          end
          default: begin
            // implied and the two unused codes
            res.done_res = 1'b1;
            res.next_pc  = prog_counter;
          end
        endcase
      end
    end else if (!st.busy) begin
      res.protocol_error = 1'b1;
    end else begin
      // finish by default; request arms below clear it again
      res.done_res     = 1'b1;
      res.next_pc      = st.pc_copy;
      st_next.busy     = 1'b0;
      st_next.phase    = eau_pkg::PH_OPLO;
      case (st.phase)
        eau_pkg::PH_OPLO: begin
          case (st.active_mode)
            eau_pkg::MODE_ABS, eau_pkg::MODE_IND, eau_pkg::MODE_ABSX,
            eau_pkg::MODE_ABSY: begin
              st_next.address_build = read_data;
              st_next.busy          = 1'b1;
              st_next.phase         = eau_pkg::PH_OPHI;
              res.done_res          = 1'b0;
              res.next_pc           = '0;
              res.read_address      = pc_inc1;
            end
            eau_pkg::MODE_ZP: begin
              res.effective_address = {8'h00, read_data};
              res.next_pc           = pc_inc1;
            end
            eau_pkg::MODE_ZPX: begin
              res.effective_address = {8'h00, zp_x};
              res.next_pc           = pc_inc1;
            end
            eau_pkg::MODE_ZPY: begin
              res.effective_address = {8'h00, zp_y};
              res.next_pc           = pc_inc1;
            end
            eau_pkg::MODE_IZX, eau_pkg::MODE_IZY, eau_pkg::MODE_IPX,
            eau_pkg::MODE_IPY: begin
              case (st.active_mode)
                eau_pkg::MODE_IZX: st_next.pointer = {8'h00, zp_x};
                eau_pkg::MODE_IZY: st_next.pointer = {8'h00, zp_y};
                default:           st_next.pointer = {8'h00, read_data};
              endcase
              st_next.busy     = 1'b1;
              st_next.phase    = eau_pkg::PH_PTRLO;
              res.done_res     = 1'b0;
              res.next_pc      = '0;
              res.read_address = st_next.pointer;
            end
            default: ;
          endcase
        end
        eau_pkg::PH_OPHI: begin
          case (st.active_mode)
            eau_pkg::MODE_ABS: begin
              res.effective_address = full;
              res.next_pc           = pc_inc2;
            end
            eau_pkg::MODE_ABSX: begin
              res.effective_address = full + {8'h00, st.x_copy};
              res.next_pc           = pc_inc2;
            end
            eau_pkg::MODE_ABSY: begin
              res.effective_address = full + {8'h00, st.y_copy};
              res.next_pc           = pc_inc2;
            end
            eau_pkg::MODE_IND: begin
              st_next.pointer  = full;
              st_next.busy     = 1'b1;
              st_next.phase    = eau_pkg::PH_PTRLO;
              res.done_res     = 1'b0;
              res.next_pc      = '0;
              res.read_address = full;
            end
            default: ;
          endcase
        end
        eau_pkg::PH_PTRLO: begin
          st_next.address_build = read_data;
          case (st.active_mode)
            eau_pkg::MODE_IND: begin
              // no page wrap for the indirect jump vector
              st_next.busy     = 1'b1;
              st_next.phase    = eau_pkg::PH_PTRHI;
              res.done_res     = 1'b0;
              res.next_pc      = '0;
              res.read_address = st.pointer + 16'd1;
            end
            eau_pkg::MODE_IZX, eau_pkg::MODE_IZY, eau_pkg::MODE_IPX,
            eau_pkg::MODE_IPY: begin
              st_next.busy     = 1'b1;
              st_next.phase    = eau_pkg::PH_PTRHI;
              res.done_res     = 1'b0;
              res.next_pc      = '0;
              res.read_address = {8'h00, ptr_lo_inc};
            end
            default: ;
          endcase
        end
        default: begin
          case (st.active_mode)
            eau_pkg::MODE_IND: begin
              res.effective_address = full;
              res.next_pc           = pc_inc2;
            end
            eau_pkg::MODE_IZX, eau_pkg::MODE_IZY: begin
              res.effective_address = full;
              res.next_pc           = pc_inc1;
            end
            eau_pkg::MODE_IPX: begin
              res.effective_address = full + {8'h00, st.x_copy};
              res.next_pc           = pc_inc1;
            end
            eau_pkg::MODE_IPY: begin
              res.effective_address = full + {8'h00, st.y_copy};
              res.next_pc           = pc_inc1;
            end
            default: ;
          endcase
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/eau_out_stage.sv
`default_nettype none
module eau_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire eau_pkg::result_t res_in,
  input  wire logic             res_stall,
  output logic                  res_valid,
  output logic                  full_stalled,
  output eau_pkg::result_t      res_out
);

  logic res_valid_next;

  assign full_stalled   = res_valid & res_stall;
  assign res_valid_next = load | full_stalled;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cpu_effective_address_unit.sv
// effective address unit for the classic 8-bit addressing modes
// request channel (req_valid/req_stall): op selects a start transaction, which
// carries mode, prog_counter, index_x, index_y and accum, or a data transaction,
// which carries read_data for the last read request
// result channel (res_valid/res_stall): every request transaction yields exactly
// one result transaction: a read request (done_res low, read_address), a
// finished calculation (done_res high, effective_address, next_pc) or an error;
// protocol_error flags data while idle or a start while a calculation is open
// an accepted request's result reaches the output register in the next cycle;
// throughput is one transaction per cycle when no stalled result is held, set
// by the single output register that the step logic feeds
// a stalled result holds its payload; while it is held req_stall is high, so
// the next request waits in place
// reset clears the calculation state to idle and empties the output register
`default_nettype none
module cpu_effective_address_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic        op,
  input  wire logic [3:0]  mode,
  input  wire logic [15:0] prog_counter,
  input  wire logic [7:0]  index_x,
  input  wire logic [7:0]  index_y,
  input  wire logic [7:0]  accum,
  input  wire logic [7:0]  read_data,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic             done_res,
  output logic [15:0]      read_address,
  output logic [15:0]      effective_address,
  output logic [15:0]      next_pc,
  output logic             protocol_error
);

  eau_pkg::calc_state_t st;
  eau_pkg::calc_state_t st_next;
  eau_pkg::result_t     res_comb;
  eau_pkg::result_t     res_q;
  logic                 accept;
  logic                 full_stalled;

  assign req_stall = full_stalled;
  assign accept    = req_valid & ~full_stalled;

  eau_step u_step (
    .op           (op),
    .mode         (mode),
    .prog_counter (prog_counter),
    .index_x      (index_x),
    .index_y      (index_y),
    .accum        (accum),
    .read_data    (read_data),
    .st           (st),
    .st_next      (st_next),
    .res          (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  eau_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .res_in       (res_comb),
    .res_stall    (res_stall),
    .res_valid    (res_valid),
    .full_stalled (full_stalled),
    .res_out      (res_q)
  );

  assign done_res          = res_q.done_res;
  assign read_address      = res_q.read_address;
  assign effective_address = res_q.effective_address;
  assign next_pc           = res_q.next_pc;
  assign protocol_error    = res_q.protocol_error;

endmodule
`default_nettype wire

// File: rtl/eau_checker.sv
`default_nettype none
module eau_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_stall,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic        done_res,
  input wire logic [15:0] read_address,
  input wire logic [15:0] effective_address,
  input wire logic [15:0] next_pc,
  input wire logic        protocol_error
);

  // every accepted transaction shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> res_valid)
    else $error("accepted transaction gave no result");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(read_address)
      && $stable(effective_address) && $stable(next_pc) && $stable(done_res))
    else $error("stalled result changed");

  a_done_no_read: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> read_address == 16'h0000 && !protocol_error)
    else $error("done result carries a read address");

  a_request_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && !done_res |-> effective_address == 16'h0000 && next_pc == 16'h0000)
    else $error("read request carries address fields");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && protocol_error |-> read_address == 16'h0000)
    else $error("error result carries a read address");

endmodule

bind cpu_effective_address_unit eau_checker u_eau_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req_valid),
  .req_stall         (req_stall),
  .res_valid         (res_valid),
  .res_stall         (res_stall),
  .done_res          (done_res),
  .read_address      (read_address),
  .effective_address (effective_address),
  .next_pc           (next_pc),
  .protocol_error    (protocol_error)
);
`default_nettype wire
